### design/mcts_pkg.sv
package mcts_pkg;

   localparam int MachW  = 6;
   localparam int LoadW  = 32;
   localparam int CountW = 12;
   localparam int TaskW  = 11;

   typedef logic [MachW-1:0]  mach_type;
   typedef logic [LoadW-1:0]  load_type;
   typedef logic [CountW-1:0] count_type;
   typedef logic [TaskW-1:0]  task_type;

   localparam load_type  LoadMax  = '1;
   localparam count_type CountMax = '1;

   // load table update for one assigned task
   typedef struct packed {
      logic      en;
      mach_type  machine;
      load_type  load;
      count_type count;
   } commit_type;

   typedef struct packed {
      task_type task_index;
      mach_type chosen_machine;
      task_type slot;
      load_type new_load;
      load_type makespan;
      mach_type heavy_machine;
   } result_type;

   function automatic load_type sat_add(input load_type a, input load_type b);
      logic [LoadW:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[LoadW] ? LoadMax : s[LoadW-1:0];
   endfunction

endpackage

### design/min_completion_time_scheduler.sv
// throughput: one candidate beat per cycle while no last beat waits on a held
// response, set by the single load table read and the running minimum; the load
// table update is bypassed to the next beat
// reset: synchronous, clears the search, task counter, makespan and all
// machine loads and task counts at once through per-machine valid bits
module min_completion_time_scheduler #(
   parameter int MACHINES = 64,
   parameter int TASKS    = 2048
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [39:0]   req_tdata,   // machine, exec_time
   input  logic          req_tlast,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [103:0]  rsp_tdata    // task_index, chosen_machine, slot, new_load,
                                      // makespan, heavy_machine
);

   logic                 s1_valid_ff;
   mcts_pkg::mach_type   s1_machine_ff;
   mcts_pkg::load_type   s1_time_ff;
   logic                 s1_last_ff;

   logic                 rsp_valid_ff;
   mcts_pkg::result_type rsp_data_ff;

   logic                 stall;
   logic                 fire;
   logic                 accept;
   mcts_pkg::load_type   cur_load;
   mcts_pkg::count_type  cur_count;
   mcts_pkg::commit_type commit;
   logic                 res_valid;
   mcts_pkg::result_type res;

   assign stall      = s1_valid_ff && s1_last_ff && rsp_valid_ff && !rsp_tready;
   assign fire       = s1_valid_ff && !stall;
   assign req_tready = !stall;
   assign accept     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_machine_ff <= req_tdata[5:0];
         s1_time_ff    <= req_tdata[37:6];
         s1_last_ff    <= req_tlast;
      end
   end

   mcts_load_table #(
      .MACHINES (MACHINES)
   ) u_table (
      .clock      (clock),
      .reset      (reset),
      .rd_en      (accept),
      .rd_machine (req_tdata[5:0]),
      .wr         (commit),
      .rd_load    (cur_load),
      .rd_count   (cur_count)
   );

   mcts_search #(
      .MACHINES (MACHINES),
      .TASKS    (TASKS)
   ) u_search (
      .clock     (clock),
      .reset     (reset),
      .valid     (fire),
      .machine   (s1_machine_ff),
      .exec_time (s1_time_ff),
      .last      (s1_last_ff),
      .cur_load  (cur_load),
      .cur_count (cur_count),
      .commit    (commit),
      .res_valid (res_valid),
      .res       (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0,
                        rsp_data_ff.heavy_machine,
                        rsp_data_ff.makespan,
                        rsp_data_ff.new_load,
                        rsp_data_ff.slot,
                        rsp_data_ff.chosen_machine,
                        rsp_data_ff.task_index};

endmodule

### design/mcts_load_table.sv
module mcts_load_table #(
   parameter int MACHINES = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  rd_en,
   input  mcts_pkg::mach_type    rd_machine,
   input  mcts_pkg::commit_type  wr,
   output mcts_pkg::load_type    rd_load,
   output mcts_pkg::count_type   rd_count
);

   localparam int AW    = (MACHINES > 1) ? $clog2(MACHINES) : 1;
   localparam int WordW = mcts_pkg::CountW + mcts_pkg::LoadW;

   logic [WordW-1:0]     mem_ff [MACHINES];
   logic [MACHINES-1:0]  valid_ff;
   logic [WordW-1:0]     q_ff;
   logic                 q_valid_ff;
   mcts_pkg::mach_type   q_machine_ff;
   mcts_pkg::commit_type fwd_ff;

   logic [AW-1:0] rd_addr;
   logic [AW-1:0] wr_addr;
   logic          fwd_hit;

   assign rd_addr = AW'(rd_machine);
   assign wr_addr = AW'(wr.machine);

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr_addr] <= {wr.count, wr.load};
      end
      if (rd_en) begin
         q_ff         <= mem_ff[rd_addr];
         q_machine_ff <= rd_machine;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         q_valid_ff <= 1'b0;
         fwd_ff     <= '0;
      end else begin
         if (wr.en) begin
            valid_ff[wr_addr] <= 1'b1;
            fwd_ff            <= wr;
         end
         if (rd_en) begin
            q_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   // latest write bypasses a read taken at the same edge
   assign fwd_hit = fwd_ff.en && (fwd_ff.machine == q_machine_ff);

   always_comb begin
      if (fwd_hit) begin
         rd_load  = fwd_ff.load;
         rd_count = fwd_ff.count;
      end else if (q_valid_ff) begin
         rd_load  = q_ff[mcts_pkg::LoadW-1:0];
         rd_count = q_ff[WordW-1:mcts_pkg::LoadW];
      end else begin
         rd_load  = '0;
         rd_count = '0;
      end
   end

endmodule

### design/mcts_search.sv
module mcts_search #(
   parameter int MACHINES = 64,
   parameter int TASKS    = 2048
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  valid,
   input  mcts_pkg::mach_type    machine,
   input  mcts_pkg::load_type    exec_time,
   input  logic                  last,
   input  mcts_pkg::load_type    cur_load,
   input  mcts_pkg::count_type   cur_count,
   output mcts_pkg::commit_type  commit,
   output logic                  res_valid,
   output mcts_pkg::result_type  res
);

   mcts_pkg::load_type  best_sum_ff;
   mcts_pkg::mach_type  best_index_ff;
   mcts_pkg::count_type best_count_ff;
   logic                have_ff;
   mcts_pkg::task_type  task_counter_ff;
   mcts_pkg::load_type  max_load_ff;
   mcts_pkg::mach_type  max_index_ff;

   logic                in_range;
   mcts_pkg::load_type  sum;
   logic                take;
   mcts_pkg::load_type  cand_sum;
   mcts_pkg::mach_type  cand_index;
   mcts_pkg::count_type cand_count;
   logic                cand_have;
   logic                grow;
   mcts_pkg::load_type  max_load_in;
   mcts_pkg::mach_type  max_index_in;
   logic [mcts_pkg::TaskW:0] task_next;
   mcts_pkg::task_type  task_counter_in;

   assign in_range   = 32'(machine) < MACHINES;
   assign sum        = mcts_pkg::sat_add(cur_load, exec_time);
   assign take       = in_range && (!have_ff || (sum < best_sum_ff));
   assign cand_sum   = take ? sum : best_sum_ff;
   assign cand_index = take ? machine : best_index_ff;
   assign cand_count = take ? cur_count : best_count_ff;
   assign cand_have  = have_ff || in_range;

   assign grow         = cand_sum > max_load_ff;
   assign max_load_in  = grow ? cand_sum : max_load_ff;
   assign max_index_in = grow ? cand_index : max_index_ff;

   assign task_next       = {1'b0, task_counter_ff} + 1'b1;
   assign task_counter_in = (32'(task_next) >= TASKS) ? '0
                                                     : task_next[mcts_pkg::TaskW-1:0];

   assign res_valid = valid && last && cand_have;

   always_comb begin
      commit.en      = res_valid;
      commit.machine = cand_index;
      commit.load    = cand_sum;
      commit.count   = (cand_count == mcts_pkg::CountMax) ? cand_count
                                                          : cand_count + 1'b1;
   end

   always_comb begin
      res.task_index     = task_counter_ff;
      res.chosen_machine = cand_index;
      res.slot           = cand_count[mcts_pkg::TaskW-1:0];
      res.new_load       = cand_sum;
      res.makespan       = max_load_in;
      res.heavy_machine  = max_index_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_sum_ff     <= mcts_pkg::LoadMax;
         best_index_ff   <= '0;
         best_count_ff   <= '0;
         have_ff         <= 1'b0;
         task_counter_ff <= '0;
         max_load_ff     <= '0;
         max_index_ff    <= '0;
      end else if (valid) begin
         if (last) begin
            best_sum_ff   <= mcts_pkg::LoadMax;
            best_index_ff <= '0;
            best_count_ff <= '0;
            have_ff       <= 1'b0;
         end else begin
            best_sum_ff   <= cand_sum;
            best_index_ff <= cand_index;
            best_count_ff <= cand_count;
            have_ff       <= cand_have;
         end
         if (res_valid) begin
            max_load_ff     <= max_load_in;
            max_index_ff    <= max_index_in;
            task_counter_ff <= task_counter_in;
         end
      end
   end

endmodule
